>>> design/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// types and constants shared by the recent identifier set
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int ID_W  = 30;
    localparam int CNT_W = 5;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] ident;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic             inserted;
        logic             evict_valid;
        logic [ID_W-1:0]  evicted_ident;
        logic [CNT_W-1:0] held_count;
        logic             entry_valid;
        logic [ID_W-1:0]  entry_ident;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic load_shadow;
        logic shift_shadow;
    } t_cell_ctl;

endpackage

>>> design/frs_cell.sv
// ----------------------------------------------------------------------------
// frs_cell
// one entry of the age-ordered chain, with a shadow register for read-out
// ----------------------------------------------------------------------------
module frs_cell (
    input  logic                     i_clk,
    input  frs_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_valid,
    input  logic [frs_pkg::ID_W-1:0] i_key,
    input  logic [frs_pkg::ID_W-1:0] i_newer_ident,
    input  logic [frs_pkg::ID_W-1:0] i_older_shadow,
    output logic [frs_pkg::ID_W-1:0] o_ident,
    output logic [frs_pkg::ID_W-1:0] o_shadow,
    output logic                     o_match
);
    import frs_pkg::*;

    logic [ID_W-1:0] r_ident;
    logic [ID_W-1:0] r_shadow;

    // entry moves one step older on insert
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_ident <= i_newer_ident;
        end
    end

    // snapshot, then shift toward the newest cell during read-out
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_shadow) begin
            r_shadow <= r_ident;
        end else if (i_ctl.shift_shadow) begin
            r_shadow <= i_older_shadow;
        end
    end

    assign o_match  = i_valid && (r_ident == i_key);
    assign o_ident  = r_ident;
    assign o_shadow = r_shadow;

endmodule

>>> design/fifo_recent_id_set.sv
// ----------------------------------------------------------------------------
// fifo_recent_id_set
// set of recent identifiers with first-in-first-out replacement
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): cmd access presents an
// identifier, cmd dump reads out every held entry newest first.
// Output channel (o_out_valid / i_out_ready / o_out_item): one result per
// access, one per held entry on a dump (one invalid result when empty),
// the final result of each transaction marked by last.
// Entries sit in a chain of cells ordered by age; an access compares all
// cells at once, so its result is registered in the cycle after acceptance and
// a new access can be taken every cycle while the output is taken.
// A dump snapshots the chain into shadow registers that shift one entry per
// cycle toward the newest cell while the output is taken; no new transaction
// is taken meanwhile.
// i_cfg_wr_en / i_cfg_wr_data write the capacity; zero acts as one and
// values above MAX_ENTRIES act as MAX_ENTRIES.
// Synchronous reset empties the set, sets capacity to 16 and drops any
// pending result. A stalled output holds its result and input stays
// blocked until the result is taken.
// ----------------------------------------------------------------------------
module fifo_recent_id_set #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  frs_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output frs_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_wr_en,
    input  logic [frs_pkg::CNT_W-1:0]     i_cfg_wr_data
);
    import frs_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES + 1) : 1;
    localparam int CW = (IW > CNT_W) ? IW : CNT_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item, n_out_item;
    logic                  r_dumping, n_dumping;
    logic [CNT_W-1:0]      r_dump_cnt, n_dump_cnt;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_cap;

    t_cell_ctl             w_ctl;
    logic [ID_W-1:0]       w_ident  [MAX_ENTRIES];
    logic [ID_W-1:0]       w_shadow [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_tail;

    logic                  out_free;
    logic                  acc;
    logic                  hit;
    logic                  full;
    logic [CW-1:0]         fill_ext;
    logic [CW-1:0]         cap_ext;
    logic [CW-1:0]         cap_eff;
    logic [ID_W-1:0]       ev_ident;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_dumping && out_free;
    assign acc        = i_in_valid && o_in_ready;

    assign fill_ext = CW'(r_fill);
    assign cap_ext  = CW'(r_cap);

    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > MAX_C) begin
            cap_eff = MAX_C;
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign full = (fill_ext >= cap_eff);
    assign hit  = |w_match;

    // cell k holds the k-th newest entry
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        logic [ID_W-1:0] w_newer;
        logic [ID_W-1:0] w_older;

        if (k == 0) begin : g_head
            assign w_newer = i_in_item.ident;
        end else begin : g_body
            assign w_newer = w_ident[k-1];
        end

        if (k == MAX_ENTRIES - 1) begin : g_end
            assign w_older = '0;
        end else begin : g_mid
            assign w_older = w_shadow[k+1];
        end

        assign w_valid[k] = (CW'(k) < fill_ext);
        assign w_tail[k]  = (CW'(k + 1) == fill_ext);

        frs_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_valid        (w_valid[k]),
            .i_key          (i_in_item.ident),
            .i_newer_ident  (w_newer),
            .i_older_shadow (w_older),
            .o_ident        (w_ident[k]),
            .o_shadow       (w_shadow[k]),
            .o_match        (w_match[k])
        );
    end

    // oldest held entry
    always_comb begin
        ev_ident = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (w_tail[k]) begin
                ev_ident = ev_ident | w_ident[k];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        n_dumping   = r_dumping;
        n_dump_cnt  = r_dump_cnt;
        n_fill      = r_fill;
        w_ctl       = '0;

        if (acc) begin
            n_out_item = '0;
            if (i_in_item.cmd == CMD_DUMP) begin
                if (r_fill == '0) begin
                    n_out_valid     = 1'b1;
                    n_out_item.last = 1'b1;
                end else begin
                    n_dumping         = 1'b1;
                    n_dump_cnt        = '0;
                    w_ctl.load_shadow = 1'b1;
                end
            end else begin
                n_out_valid              = 1'b1;
                n_out_item.hit           = hit;
                n_out_item.inserted      = !hit;
                n_out_item.evict_valid   = !hit && full;
                n_out_item.evicted_ident = (!hit && full) ? ev_ident : '0;
                n_out_item.last          = 1'b1;
                w_ctl.shift              = !hit;
                if (!hit && !full) begin
                    n_fill = r_fill + 1'b1;
                end
                n_out_item.held_count = n_fill;
            end
        end else if (r_dumping && out_free) begin
            n_out_valid            = 1'b1;
            n_out_item             = '0;
            n_out_item.held_count  = r_fill;
            n_out_item.entry_valid = 1'b1;
            n_out_item.entry_ident = w_shadow[0];
            w_ctl.shift_shadow     = 1'b1;
            n_dump_cnt             = r_dump_cnt + 1'b1;
            if (r_dump_cnt + 1'b1 == r_fill) begin
                n_out_item.last = 1'b1;
                n_dumping       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_dumping   <= 1'b0;
            r_dump_cnt  <= '0;
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            r_dumping   <= n_dumping;
            r_dump_cnt  <= n_dump_cnt;
            r_fill      <= n_fill;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_ext <= MAX_C)
        else $error("fill count above entry count");

    a_dump_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dumping |-> (r_dump_cnt < r_fill))
        else $error("read-out index past held entries");

    a_hit_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_item.cmd == CMD_ACCESS && hit) |=> $stable(r_fill))
        else $error("hit changed fill count");

    a_count_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.inserted || o_out_item.entry_valid))
            |-> (o_out_item.held_count == r_fill))
        else $error("held count out of step with fill");
`endif

endmodule
